// ----- src/mepg_pkg.sv -----
// Shared types and codes for the midpoint ellipse point generator.
`timescale 1ns / 1ps

package mepg_pkg;

    // Width of the rectangle size fields on the input channel.
    localparam int RECT_W = 12;
    // Width of coordinates on both channels.
    localparam int COORD_W = 16;
    // Width of the colour word.
    localparam int COLOR_W = 32;
    // Default number of size bits that are honored.
    localparam int SIZE_BITS_DEFAULT = 12;

    // Operation codes of an input word.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_EDGE  = 2'd2;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]        color;
        logic                      last;
        logic                      done_res;
    } word_t;

endpackage

// ----- src/midpoint_ellipse_point_generator.sv -----
// Top level of the midpoint ellipse point generator: sequencer and walk state.
`timescale 1ns / 1ps

// Midpoint ellipse point generator. A start word with a rectangle sets up the
// walk through the setup states SU_AA to SU_E and produces nothing, or, when a
// radius is zero, one edge line word that passes through the edge state and the
// output register, with the block ready again once that register takes it.
// Each step word produces four mirrored point words at one per cycle while the
// result side takes them, followed by the update states UPD1 to UPD3 and, when
// the walk moves a row or column, UPD4; the step that crosses into the second
// region first passes through its setup states R2_D to R2_E, and the final step
// yields one done word. One registered multiplier forms every product of the
// walk, and there is a single result port. The block takes no input word while
// it works; the colour register may be written while idle.
module midpoint_ellipse_point_generator #(
    parameter int SIZE_BITS = mepg_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mepg_pkg::COLOR_W-1:0]           cfg_data,
    // Input channel.
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_op,
    input  logic signed [mepg_pkg::COORD_W-1:0]    s_rect_x,
    input  logic signed [mepg_pkg::COORD_W-1:0]    s_rect_y,
    input  logic [mepg_pkg::RECT_W-1:0]            s_rect_w,
    input  logic [mepg_pkg::RECT_W-1:0]            s_rect_h,
    // Result channel.
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_kind,
    output logic signed [mepg_pkg::COORD_W-1:0]    m_point_x,
    output logic signed [mepg_pkg::COORD_W-1:0]    m_point_y,
    output logic signed [mepg_pkg::COORD_W-1:0]    m_end_x,
    output logic signed [mepg_pkg::COORD_W-1:0]    m_end_y,
    output logic [mepg_pkg::COLOR_W-1:0]           m_color,
    output logic                                   m_last,
    output logic                                   m_done_res
);

    import mepg_pkg::*;

    // Honored size bits, radius, walk, multiplier and error widths.
    localparam int USED_W = (SIZE_BITS < RECT_W) ? SIZE_BITS : RECT_W;
    localparam int RAD_W  = USED_W;
    localparam int WALK_W = RAD_W + 2;
    localparam int MA_W   = 2 * RAD_W + 2;
    localparam int MB_W   = WALK_W;
    localparam int P_W    = MA_W + MB_W;
    localparam int ERR_W  = P_W + 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2,
        PH_DONE
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SU_AA,
        ST_SU_BB,
        ST_SU_D,
        ST_SU_S,
        ST_SU_E,
        ST_CHECK,
        ST_R2_D,
        ST_R2_S,
        ST_R2_E,
        ST_EMIT,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3,
        ST_UPD4,
        ST_EDGE,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic                      changed_reg, changed_next;
    logic [COLOR_W-1:0]        color_reg;
    logic [RAD_W-1:0]          rad_a_reg, rad_a_next;
    logic [RAD_W-1:0]          rad_b_reg, rad_b_next;
    logic signed [WALK_W-1:0]  walk_x_reg, walk_x_next;
    logic signed [WALK_W-1:0]  walk_y_reg, walk_y_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   stop_x_reg, stop_x_next;
    logic signed [ERR_W-1:0]   stop_y_reg, stop_y_next;
    logic signed [MA_W-1:0]    a2_reg, a2_next;
    logic signed [MA_W-1:0]    b2_reg, b2_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next;
    logic signed [COORD_W-1:0] cy_reg, cy_next;
    logic [1:0]                odd_reg, odd_next;
    word_t                     edge_reg, edge_next;

    logic [RECT_W-1:0]         w_in, h_in;
    logic [RAD_W-1:0]          a_in, b_in;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [P_W-1:0]     mul_p;
    logic signed [ERR_W-1:0]   prod_ext;
    logic                      out_load, out_free;
    word_t                     out_word, pt_word, res_word;
    logic signed [COORD_W-1:0] x_plus, x_minus, y_plus, y_minus;

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    // Input words are taken only while the sequencer waits.
    assign s_ready = (state_reg == ST_IDLE);

    // Rectangle size reduced to the honored bits, and the radii from it.
    assign w_in = RECT_W'(s_rect_w[USED_W-1:0]);
    assign h_in = RECT_W'(s_rect_h[USED_W-1:0]);
    assign a_in = RAD_W'(w_in >> 1);
    assign b_in = RAD_W'(h_in >> 1);

    assign prod_ext = ERR_W'(mul_p);

    mepg_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    // Operand selection for the shared multiplier, by sequencer state.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SU_AA: begin
                mul_a = MA_W'(rad_a_reg);
                mul_b = MB_W'(rad_a_reg);
            end
            ST_SU_BB: begin
                mul_a = MA_W'(rad_b_reg);
                mul_b = MB_W'(rad_b_reg);
            end
            ST_SU_D: begin
                mul_a = a2_reg >>> 1;
                mul_b = MB_W'(rad_b_reg);
            end
            ST_SU_S: begin
                mul_a = a2_reg;
                mul_b = MB_W'(rad_b_reg);
            end
            ST_R2_D: begin
                mul_a = b2_reg >>> 1;
                mul_b = MB_W'(rad_a_reg);
            end
            ST_R2_S: begin
                mul_a = b2_reg;
                mul_b = MB_W'(rad_a_reg);
            end
            ST_UPD1: begin
                if (phase_reg == PH_R1) begin
                    mul_a = b2_reg;
                    mul_b = walk_x_reg;
                end else begin
                    mul_a = a2_reg;
                    mul_b = walk_y_reg;
                end
            end
            ST_UPD3: begin
                if (phase_reg == PH_R1) begin
                    mul_a = a2_reg;
                    mul_b = walk_y_reg - WALK_W'(1);
                end else begin
                    mul_a = b2_reg;
                    mul_b = walk_x_reg - WALK_W'(1);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The four mirrored points of the current walk position.
    assign x_plus  = cx_reg + COORD_W'(walk_x_reg) - COORD_W'(odd_reg[0]);
    assign x_minus = cx_reg - COORD_W'(walk_x_reg);
    assign y_plus  = cy_reg + COORD_W'(walk_y_reg) - COORD_W'(odd_reg[1]);
    assign y_minus = cy_reg - COORD_W'(walk_y_reg);

    always_comb begin
        pt_word.kind     = changed_reg ? KIND_LINE : KIND_PIXEL;
        pt_word.point_x  = (cnt_reg == 2'd0 || cnt_reg == 2'd3) ? x_plus : x_minus;
        pt_word.point_y  = (cnt_reg == 2'd0 || cnt_reg == 2'd1) ? y_plus : y_minus;
        pt_word.end_x    = changed_reg ? cx_reg : '0;
        pt_word.end_y    = changed_reg ? cy_reg : '0;
        pt_word.color    = color_reg;
        pt_word.last     = (cnt_reg == 2'd3);
        pt_word.done_res = 1'b0;
    end

    // Word offered to the output register.
    always_comb begin
        out_load = 1'b0;
        out_word = pt_word;
        unique case (state_reg)
            ST_EMIT: begin
                out_load = 1'b1;
                out_word = pt_word;
            end
            ST_EDGE: begin
                out_load = 1'b1;
                out_word = edge_reg;
                out_word.color = color_reg;
            end
            ST_DONE: begin
                out_load          = 1'b1;
                out_word          = '0;
                out_word.kind     = KIND_PIXEL;
                out_word.color    = color_reg;
                out_word.last     = 1'b1;
                out_word.done_res = 1'b1;
            end
            default: begin
                out_load = 1'b0;
                out_word = pt_word;
            end
        endcase
    end

    // Sequencer: setup, region checks, point emission, walk update and the edge and done words.
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        changed_next = changed_reg;
        rad_a_next   = rad_a_reg;
        rad_b_next   = rad_b_reg;
        walk_x_next  = walk_x_reg;
        walk_y_next  = walk_y_reg;
        err_next     = err_reg;
        stop_x_next  = stop_x_reg;
        stop_y_next  = stop_y_reg;
        a2_next      = a2_reg;
        b2_next      = b2_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        odd_next     = odd_reg;
        edge_next    = edge_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_START) begin
                        rad_a_next = a_in;
                        rad_b_next = b_in;
                        edge_next          = '0;
                        edge_next.kind     = KIND_EDGE;
                        edge_next.point_x  = s_rect_x;
                        edge_next.point_y  = s_rect_y;
                        edge_next.last     = 1'b1;
                        edge_next.done_res = 1'b1;
                        if (a_in == '0) begin
                            // Vertical edge line down the left side.
                            edge_next.end_x = s_rect_x;
                            edge_next.end_y = s_rect_y + COORD_W'(h_in) - COORD_W'(1);
                            phase_next = PH_IDLE;
                            state_next = ST_EDGE;
                        end else if (b_in == '0) begin
                            // Horizontal edge line along the top.
                            edge_next.end_x = s_rect_x + COORD_W'(w_in) - COORD_W'(1);
                            edge_next.end_y = s_rect_y;
                            phase_next = PH_IDLE;
                            state_next = ST_EDGE;
                        end else begin
                            cx_next      = s_rect_x + COORD_W'(a_in);
                            cy_next      = s_rect_y + COORD_W'(b_in);
                            odd_next     = {!h_in[0], !w_in[0]};
                            walk_x_next  = '0;
                            walk_y_next  = WALK_W'(b_in);
                            stop_y_next  = '0;
                            changed_next = 1'b0;
                            phase_next   = PH_R1;
                            state_next   = ST_SU_AA;
                        end
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SU_AA: begin
                state_next = ST_SU_BB;
            end
            ST_SU_BB: begin
                a2_next    = MA_W'(mul_p <<< 1);
                state_next = ST_SU_D;
            end
            ST_SU_D: begin
                b2_next    = MA_W'(mul_p <<< 1);
                state_next = ST_SU_S;
            end
            ST_SU_S: begin
                err_next   = prod_ext;
                state_next = ST_SU_E;
            end
            ST_SU_E: begin
                stop_x_next = prod_ext;
                state_next  = ST_IDLE;
            end
            ST_CHECK: begin
                unique case (phase_reg)
                    PH_R1: begin
                        if (stop_y_reg <= stop_x_reg) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_R2_D;
                        end
                    end
                    PH_R2: begin
                        if (stop_y_reg >= stop_x_reg) begin
                            state_next = ST_EMIT;
                        end else begin
                            phase_next = PH_DONE;
                            state_next = ST_DONE;
                        end
                    end
                    PH_DONE: begin
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_R2_D: begin
                walk_x_next  = WALK_W'(rad_a_reg);
                walk_y_next  = '0;
                stop_x_next  = '0;
                changed_next = 1'b0;
                phase_next   = PH_R2;
                state_next   = ST_R2_S;
            end
            ST_R2_S: begin
                err_next   = prod_ext;
                state_next = ST_R2_E;
            end
            ST_R2_E: begin
                stop_y_next = prod_ext;
                state_next  = ST_CHECK;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (cnt_reg == 2'd3) begin
                        cnt_next     = '0;
                        changed_next = 1'b0;
                        state_next   = ST_UPD1;
                    end else begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            ST_UPD1: begin
                if (phase_reg == PH_R1) begin
                    walk_x_next = walk_x_reg + WALK_W'(1);
                end else begin
                    walk_y_next = walk_y_reg + WALK_W'(1);
                end
                state_next = ST_UPD2;
            end
            ST_UPD2: begin
                err_next = err_reg - prod_ext;
                if (phase_reg == PH_R1) begin
                    stop_y_next = stop_y_reg + ERR_W'(b2_reg);
                end else begin
                    stop_x_next = stop_x_reg + ERR_W'(a2_reg);
                end
                state_next = ST_UPD3;
            end
            ST_UPD3: begin
                // Region one moves a row on a non-positive error, region two
                // moves a column on a negative one.
                if (phase_reg == PH_R1) begin
                    if (err_reg[ERR_W-1] || err_reg == '0) begin
                        state_next = ST_UPD4;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    if (err_reg[ERR_W-1]) begin
                        state_next = ST_UPD4;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_UPD4: begin
                err_next     = err_reg + prod_ext;
                changed_next = 1'b1;
                if (phase_reg == PH_R1) begin
                    walk_y_next = walk_y_reg - WALK_W'(1);
                    stop_x_next = stop_x_reg - ERR_W'(a2_reg);
                end else begin
                    walk_x_next = walk_x_reg - WALK_W'(1);
                    stop_y_next = stop_y_reg - ERR_W'(b2_reg);
                end
                state_next = ST_IDLE;
            end
            ST_EDGE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    phase_next = PH_IDLE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, walk registers and the colour register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            changed_reg <= 1'b0;
            color_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            changed_reg <= changed_next;
            if (cfg_valid && cfg_ready) begin
                color_reg <= cfg_data;
            end
        end
        rad_a_reg  <= rad_a_next;
        rad_b_reg  <= rad_b_next;
        walk_x_reg <= walk_x_next;
        walk_y_reg <= walk_y_next;
        err_reg    <= err_next;
        stop_x_reg <= stop_x_next;
        stop_y_reg <= stop_y_next;
        a2_reg     <= a2_next;
        b2_reg     <= b2_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        odd_reg    <= odd_next;
        edge_reg   <= edge_next;
    end

    mepg_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (out_load),
        .din     (out_word),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dout    (res_word)
    );

    assign m_kind     = res_word.kind;
    assign m_point_x  = res_word.point_x;
    assign m_point_y  = res_word.point_y;
    assign m_end_x    = res_word.end_x;
    assign m_end_y    = res_word.end_y;
    assign m_color    = res_word.color;
    assign m_last     = res_word.last;
    assign m_done_res = res_word.done_res;

endmodule

// ----- src/mepg_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module mepg_mul #(
    parameter int A_W = 26,
    parameter int B_W = 14
) (
    input  logic                     aclk,
    input  logic signed [A_W-1:0]    op_a,
    input  logic signed [B_W-1:0]    op_b,
    output logic signed [A_W+B_W-1:0] product
);

    logic signed [A_W+B_W-1:0] product_reg;

    // The product is ready in the cycle after the operands are presented.
    always_ff @(posedge aclk) begin
        product_reg <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
    end

    assign product = product_reg;

endmodule

// ----- src/mepg_obuf.sv -----
// Output register that holds one result word toward the result channel.
`timescale 1ns / 1ps

module mepg_obuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  mepg_pkg::word_t din,
    output logic            free,
    output logic            m_valid,
    input  logic            m_ready,
    output mepg_pkg::word_t dout
);

    import mepg_pkg::*;

    logic  valid_reg;
    word_t data_reg;

    // A new word may enter when the register is empty or being drained.
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load && free) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            data_reg <= din;
        end
    end

    assign m_valid = valid_reg;
    assign dout    = data_reg;

endmodule
